// ===== hdl/qtu_pkg.sv =====
// Package for the Q-table update engine: sizes, request and register codes,
// and the command and result structs used on the top-level ports.
// Depends on nothing; q_table_update and qtu_mul use scoped names, the testbench imports it.
`default_nettype none

package qtu_pkg;

    // Table geometry
    localparam int NUM_STATES = 8;
    localparam int DEPTH      = NUM_STATES * NUM_STATES;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int SLOTS      = 2 ** ADDR_W;
    localparam int CNT_W      = $clog2(NUM_STATES + 1);

    // Field and datapath widths
    localparam int REQ_W    = 2;
    localparam int IDX_W    = 3;
    localparam int Q_W      = 24;
    localparam int REW_W    = 8;
    localparam int FRAC_W   = 12;
    localparam int COEF_W   = 16;
    localparam int DIFF_W   = Q_W + 1;
    localparam int PROD_W   = COEF_W + DIFF_W;

    localparam logic [Q_W-1:0] Q_MAX = {Q_W{1'b1}};

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 2'd1;
    localparam logic [COEF_W-1:0] LEARN_RATE_RESET = 16'd6554;
    localparam logic [COEF_W-1:0] DISCOUNT_RESET   = 16'd39322;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [IDX_W-1:0] from_state;
        logic [IDX_W-1:0] to_state;
        logic [REW_W-1:0] reward_in;
    } t_cmd;

    typedef struct packed {
        logic [Q_W-1:0] q_value;
        logic [Q_W-1:0] best_next;
        logic           no_action;
    } t_res;

endpackage

`default_nettype wire

// ===== hdl/q_table_update.sv =====
// Q-table update engine. busy drops in the result cycle, so a new request can
// be taken as soon as the result is out. An unknown or out-of-range request is
// answered from idle; load and read pass through issue and Q read, and an update
// through a row scan of one table port cycle per entry, then fetch to apply.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Synchronous active-low reset; both tables read as zero right after reset.
`default_nettype none

module q_table_update (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire qtu_pkg::t_cmd                  i_cmd,
    output logic                                o_done,
    output qtu_pkg::t_res                       o_res,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [qtu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [qtu_pkg::COEF_W-1:0]     i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ISSUE = 9'b000000010,
        S_RDQ   = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_FETCH = 9'b000010000,
        S_GB    = 9'b000100000,
        S_TGT   = 9'b001000000,
        S_DELTA = 9'b010000000,
        S_APPLY = 9'b100000000
    } t_state;

    // Control registers
    t_state                          r_state, n_state;
    logic                            r_done, n_done;
    logic [qtu_pkg::COEF_W-1:0]      r_learn, r_discount;
    logic [qtu_pkg::SLOTS-1:0]       r_qv, r_rv;
    logic                            r_qv_rd, r_rv_rd;
    logic [qtu_pkg::CNT_W-1:0]       r_cnt, n_cnt;

    // Payload registers
    logic [qtu_pkg::REQ_W-1:0]       r_req, n_req;
    logic [qtu_pkg::ADDR_W-1:0]      r_idx, n_idx;
    logic [qtu_pkg::ADDR_W-1:0]      r_row, n_row;
    logic [qtu_pkg::REW_W-1:0]       r_rew_in, n_rew_in;
    logic [qtu_pkg::Q_W-1:0]         r_best, n_best;
    logic                            r_found, n_found;
    logic [qtu_pkg::Q_W-1:0]         r_q, n_q;
    logic [qtu_pkg::REW_W-1:0]       r_rew, n_rew;
    logic [qtu_pkg::DIFF_W-1:0]      r_diff, n_diff;
    logic                            r_neg, n_neg;
    qtu_pkg::t_res                   r_res, n_res;

    // Table ports and multiplier hookup
    logic                            c_accept;
    logic [qtu_pkg::ADDR_W-1:0]      c_addr;
    logic                            c_q_we, c_rw_we;
    logic [qtu_pkg::Q_W-1:0]         c_q_wdata;
    logic [qtu_pkg::Q_W-1:0]         c_q_rdata, c_q_masked;
    logic [qtu_pkg::REW_W-1:0]       c_rw_rdata, c_rw_masked;
    logic [qtu_pkg::COEF_W-1:0]      c_coef;
    logic [qtu_pkg::DIFF_W-1:0]      c_opnd, c_prod;
    logic                            c_bad;
    logic                            c_allowed;
    logic [qtu_pkg::DIFF_W-1:0]      c_target;
    logic [qtu_pkg::DIFF_W:0]        c_sum;

    assign c_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

    // Entries never written read as zero
    assign c_q_masked  = r_qv_rd ? c_q_rdata : '0;
    assign c_rw_masked = r_rv_rd ? c_rw_rdata : '0;
    assign c_allowed   = (c_rw_masked != '0);

    assign c_bad = ((i_cmd.req_type != qtu_pkg::REQ_LOAD) &&
                    (i_cmd.req_type != qtu_pkg::REQ_UPDATE) &&
                    (i_cmd.req_type != qtu_pkg::REQ_READ)) ||
                   (int'(i_cmd.from_state) >= qtu_pkg::NUM_STATES) ||
                   (int'(i_cmd.to_state) >= qtu_pkg::NUM_STATES);

    // Target and saturating sum for the delta step
    assign c_target = qtu_pkg::DIFF_W'({r_rew, {qtu_pkg::FRAC_W{1'b0}}}) +
                      qtu_pkg::DIFF_W'(c_prod[qtu_pkg::Q_W-1:0]);
    assign c_sum    = (qtu_pkg::DIFF_W + 1)'(r_q) + (qtu_pkg::DIFF_W + 1)'(c_prod);

    // Multiplier operands: gamma * best first, then alpha * |diff|
    assign c_coef = (r_state == S_GB) ? r_discount : r_learn;
    assign c_opnd = (r_state == S_GB) ? qtu_pkg::DIFF_W'(r_best) : r_diff;

    qtu_mul u_mul (
        .i_clk  (i_clk),
        .i_coef (c_coef),
        .i_opnd (c_opnd),
        .o_prod (c_prod)
    );

    qtu_ram #(
        .WIDTH (qtu_pkg::Q_W),
        .DEPTH (qtu_pkg::DEPTH)
    ) u_q_ram (
        .i_clk   (i_clk),
        .i_we    (c_q_we),
        .i_addr  (c_addr),
        .i_wdata (c_q_wdata),
        .o_rdata (c_q_rdata)
    );

    qtu_ram #(
        .WIDTH (qtu_pkg::REW_W),
        .DEPTH (qtu_pkg::DEPTH)
    ) u_rw_ram (
        .i_clk   (i_clk),
        .i_we    (c_rw_we),
        .i_addr  (c_addr),
        .i_wdata (r_rew_in),
        .o_rdata (c_rw_rdata)
    );

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_req    = r_req;
        n_idx    = r_idx;
        n_row    = r_row;
        n_rew_in = r_rew_in;
        n_best   = r_best;
        n_found  = r_found;
        n_q      = r_q;
        n_rew    = r_rew;
        n_diff   = r_diff;
        n_neg    = r_neg;
        n_res    = r_res;
        c_addr    = r_idx;
        c_q_we    = 1'b0;
        c_rw_we   = 1'b0;
        c_q_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    n_req    = i_cmd.req_type;
                    n_rew_in = i_cmd.reward_in;
                    n_idx    = qtu_pkg::ADDR_W'(int'(i_cmd.from_state) *
                               qtu_pkg::NUM_STATES + int'(i_cmd.to_state));
                    n_row    = qtu_pkg::ADDR_W'(int'(i_cmd.to_state) *
                               qtu_pkg::NUM_STATES);
                    if (c_bad) begin
                        n_res  = '0;
                        n_done = 1'b1;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                // Load writes the reward and reads Q at the same entry
                c_rw_we = (r_req == qtu_pkg::REQ_LOAD);
                n_cnt   = '0;
                n_best  = '0;
                n_found = 1'b0;
                n_state = (r_req == qtu_pkg::REQ_UPDATE) ? S_SCAN : S_RDQ;
            end
            S_RDQ: begin
                n_res.q_value   = c_q_masked;
                n_res.best_next = '0;
                n_res.no_action = 1'b0;
                n_done          = 1'b1;
                n_state         = S_IDLE;
            end
            S_SCAN: begin
                // Issue one successor address, fold in the previous one
                if (r_cnt != qtu_pkg::CNT_W'(qtu_pkg::NUM_STATES)) begin
                    c_addr = r_row + qtu_pkg::ADDR_W'(r_cnt);
                end
                if (r_cnt != '0 && c_allowed) begin
                    if (!r_found || c_q_masked > r_best) begin
                        n_best = c_q_masked;
                    end
                    n_found = 1'b1;
                end
                if (r_cnt == qtu_pkg::CNT_W'(qtu_pkg::NUM_STATES)) begin
                    n_state = S_FETCH;
                end else begin
                    n_cnt = r_cnt + qtu_pkg::CNT_W'(1);
                end
            end
            S_FETCH: begin
                n_state = S_GB;
            end
            S_GB: begin
                n_q     = c_q_masked;
                n_rew   = c_rw_masked;
                n_state = S_TGT;
            end
            S_TGT: begin
                if (c_target >= qtu_pkg::DIFF_W'(r_q)) begin
                    n_diff = c_target - qtu_pkg::DIFF_W'(r_q);
                    n_neg  = 1'b0;
                end else begin
                    n_diff = qtu_pkg::DIFF_W'(r_q) - c_target;
                    n_neg  = 1'b1;
                end
                n_state = S_DELTA;
            end
            S_DELTA: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                // Saturate at both ends and write back
                if (!r_neg) begin
                    c_q_wdata = (c_sum > (qtu_pkg::DIFF_W + 1)'(qtu_pkg::Q_MAX)) ?
                                qtu_pkg::Q_MAX : c_sum[qtu_pkg::Q_W-1:0];
                end else if (c_prod > qtu_pkg::DIFF_W'(r_q)) begin
                    c_q_wdata = '0;
                end else begin
                    c_q_wdata = r_q - c_prod[qtu_pkg::Q_W-1:0];
                end
                c_q_we          = 1'b1;
                n_res.q_value   = c_q_wdata;
                n_res.best_next = r_best;
                n_res.no_action = !r_found;
                n_done          = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, valid bits and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_cnt      <= '0;
            r_qv       <= '0;
            r_rv       <= '0;
            r_qv_rd    <= 1'b0;
            r_rv_rd    <= 1'b0;
            r_learn    <= qtu_pkg::LEARN_RATE_RESET;
            r_discount <= qtu_pkg::DISCOUNT_RESET;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
            r_qv_rd <= r_qv[c_addr];
            r_rv_rd <= r_rv[c_addr];
            if (c_q_we) begin
                r_qv[c_addr] <= 1'b1;
            end
            if (c_rw_we) begin
                r_rv[c_addr] <= 1'b1;
            end
            // Take a register transfer; ignore indexes beyond the list
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    qtu_pkg::CFG_LEARN_RATE: r_learn    <= i_cfg_data;
                    qtu_pkg::CFG_DISCOUNT:   r_discount <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_row    <= n_row;
        r_rew_in <= n_rew_in;
        r_best   <= n_best;
        r_found  <= n_found;
        r_q      <= n_q;
        r_rew    <= n_rew;
        r_diff   <= n_diff;
        r_neg    <= n_neg;
        r_res    <= n_res;
    end

endmodule

`default_nettype wire

// ===== hdl/qtu_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing; width and depth come from its parameters.
`default_nettype none

module qtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, always register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/qtu_mul.sv =====
// Shared fraction multiplier: registered (coef * operand) >> 16.
// Depends on qtu_pkg for the coefficient and operand widths.
`default_nettype none

module qtu_mul (
    input  wire logic                        i_clk,
    input  wire logic [qtu_pkg::COEF_W-1:0] i_coef,
    input  wire logic [qtu_pkg::DIFF_W-1:0] i_opnd,
    output logic      [qtu_pkg::DIFF_W-1:0] o_prod
);

    logic [qtu_pkg::PROD_W-1:0] c_full;
    logic [qtu_pkg::DIFF_W-1:0] r_prod;

    assign c_full = qtu_pkg::PROD_W'(i_coef) * qtu_pkg::PROD_W'(i_opnd);

    // Drop the fraction bits of the coefficient
    always_ff @(posedge i_clk) begin
        r_prod <= c_full[qtu_pkg::PROD_W-1:qtu_pkg::COEF_W];
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== tb/tb_q_table_update.sv =====
// Self-checking testbench for q_table_update: a directed table, then random
// load, update, read and unknown-request traffic under several learn-rate and
// discount settings. Depends on qtu_pkg and the q_table_update RTL only.
`timescale 1ns / 100ps

module tb_q_table_update;

    import qtu_pkg::*;

    // Request code with no meaning to the block
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
    // Configuration indexes past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int NUM_PHASES     = 7;
    localparam int PHASE_ITEMS    = 128;
    localparam int SATURATE_RUNS  = 40;
    localparam int SETTLE_CYCLES  = 3 * NUM_STATES + 21;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        t_cmd cmd;
        bit   exact;
        t_res res;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic o_done;
    t_res o_res;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COEF_W-1:0] i_cfg_data;

    // Shadow copy of the block's tables and coefficients
    logic [Q_W-1:0]    q_shadow   [DEPTH];
    logic [REW_W-1:0]  rew_shadow [DEPTH];
    logic [COEF_W-1:0] alpha_shadow;
    logic [COEF_W-1:0] gamma_shadow;

    t_res     q_results_due [$];
    dir_row_t dir_rows [$];
    t_res     oldest_due;
    int       n_errors;
    int       idle_cycles;
    int       walk_state;
    bit       allow_gaps;

    logic [COEF_W-1:0] ph_alpha [NUM_PHASES];
    logic [COEF_W-1:0] ph_gamma [NUM_PHASES];

    q_table_update u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Apply one command to the shadow tables and return the result it yields
    function automatic t_res qlearn_step(input t_cmd c);
        t_res        r;
        int          idx;
        int          k;
        bit          found;
        logic [63:0] best;
        logic [63:0] qv;
        logic [63:0] gb;
        logic [63:0] target;
        logic [63:0] delta;
        logic [63:0] nxt;
        r = '0;
        if (c.req_type == REQ_NONE || int'(c.from_state) >= NUM_STATES
                || int'(c.to_state) >= NUM_STATES) begin
            return r;
        end
        idx = int'(c.from_state) * NUM_STATES + int'(c.to_state);
        case (c.req_type)
            REQ_LOAD: begin
                rew_shadow[idx] = c.reward_in;
                r.q_value = q_shadow[idx];
            end
            REQ_READ: begin
                r.q_value = q_shadow[idx];
            end
            default: begin
                // Scan the successor row of the destination for its best Q
                found = 1'b0;
                best = '0;
                for (int j = 0; j < NUM_STATES; j++) begin
                    k = int'(c.to_state) * NUM_STATES + j;
                    if (rew_shadow[k] != '0) begin
                        if (!found || 64'(q_shadow[k]) > best) best = 64'(q_shadow[k]);
                        found = 1'b1;
                    end
                end
                qv = 64'(q_shadow[idx]);
                gb = ({48'd0, gamma_shadow} * best) >> 16;
                target = ({56'd0, rew_shadow[idx]} << FRAC_W) + gb;
                if (target >= qv) begin
                    delta = ({48'd0, alpha_shadow} * (target - qv)) >> 16;
                    nxt = qv + delta;
                    if (nxt > {40'd0, Q_MAX}) nxt = {40'd0, Q_MAX};
                end else begin
                    delta = ({48'd0, alpha_shadow} * (qv - target)) >> 16;
                    nxt = (delta > qv) ? 64'd0 : qv - delta;
                end
                q_shadow[idx] = nxt[Q_W-1:0];
                r.q_value = nxt[Q_W-1:0];
                r.best_next = best[Q_W-1:0];
                r.no_action = !found;
            end
        endcase
        return r;
    endfunction

    // Draw a random command; most updates follow a walk over allowed transitions
    function automatic t_cmd pick_cmd();
        t_cmd c;
        int   sel;
        int   top;
        int   succ [$];
        int   r;
        sel = $urandom_range(0, 99);
        top = ($urandom_range(0, 1) == 0) ? 3 : NUM_STATES - 1;
        c.req_type = REQ_READ;
        c.from_state = IDX_W'($urandom_range(0, top));
        c.to_state = IDX_W'($urandom_range(0, top));
        c.reward_in = REW_W'($urandom_range(0, 255));
        if (sel < 20) begin
            c.req_type = REQ_LOAD;
            r = $urandom_range(0, 9);
            if (r < 3) c.reward_in = '0;
            else if (r == 3) c.reward_in = '1;
            else if (r == 4) c.reward_in = 8'd1;
        end else if (sel < 75) begin
            c.req_type = REQ_UPDATE;
            for (int j = 0; j < NUM_STATES; j++) begin
                if (rew_shadow[walk_state * NUM_STATES + j] != '0) begin
                    succ.insert(succ.size(), j);
                end
            end
            if (succ.size() != 0 && $urandom_range(0, 7) != 0) begin
                c.from_state = IDX_W'(walk_state);
                c.to_state = IDX_W'(succ[$urandom_range(0, succ.size() - 1)]);
            end
            walk_state = int'(c.to_state);
        end else if (sel >= 93) begin
            c.req_type = REQ_NONE;
        end
        return c;
    endfunction

    task automatic add_row(input logic [REQ_W-1:0] req, input int from, input int to,
                           input int rew, input bit exact, input int qv, input int best,
                           input bit na);
        dir_row_t row;
        row.cmd.req_type = req;
        row.cmd.from_state = IDX_W'(from);
        row.cmd.to_state = IDX_W'(to);
        row.cmd.reward_in = REW_W'(rew);
        row.exact = exact;
        row.res.q_value = Q_W'(qv);
        row.res.best_next = Q_W'(best);
        row.res.no_action = na;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Hold start and the command until the block takes it; leave start high
    task automatic send_cmd(input t_cmd c, input bit exact, input t_res typed);
        t_res due;
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        due = qlearn_step(c);
        q_results_due.insert(q_results_due.size(), exact ? typed : due);
    endtask

    task automatic sender_gap();
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
    endtask

    // Drop start, wait for every outstanding result, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (q_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        if (allow_gaps) repeat ($urandom_range(0, 3)) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LEARN_RATE) alpha_shadow = data;
        else if (idx == CFG_DISCOUNT) gamma_shadow = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (q_results_due.size() == 0) begin
                $display("%0t: result with nothing expected: q=%h best=%h na=%b",
                         $realtime, o_res.q_value, o_res.best_next, o_res.no_action);
                n_errors++;
            end else begin
                oldest_due = q_results_due.pop_front();
                if (o_res.q_value !== oldest_due.q_value) begin
                    $display("%0t: q_value expected %h actual %h",
                             $realtime, oldest_due.q_value, o_res.q_value);
                    n_errors++;
                end
                if (o_res.best_next !== oldest_due.best_next) begin
                    $display("%0t: best_next expected %h actual %h",
                             $realtime, oldest_due.best_next, o_res.best_next);
                    n_errors++;
                end
                if (o_res.no_action !== oldest_due.no_action) begin
                    $display("%0t: no_action expected %b actual %b",
                             $realtime, oldest_due.no_action, o_res.no_action);
                    n_errors++;
                end
            end
        end
    end

    // End the run when no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, queue holds %0d", $realtime,
                         q_results_due.size());
                $display("** q_table_update: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        t_cmd c;
        t_res none;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        n_errors = 0;
        idle_cycles = 0;
        walk_state = 0;
        allow_gaps = 1'b1;
        none = '0;
        for (int k = 0; k < DEPTH; k++) begin
            q_shadow[k] = '0;
            rew_shadow[k] = '0;
        end
        alpha_shadow = LEARN_RATE_RESET;
        gamma_shadow = DISCOUNT_RESET;

        ph_alpha[0] = LEARN_RATE_RESET;  ph_gamma[0] = DISCOUNT_RESET;
        ph_alpha[1] = '1;                ph_gamma[1] = '1;
        ph_alpha[2] = '0;                ph_gamma[2] = '0;
        ph_alpha[3] = '1;                ph_gamma[3] = '0;
        ph_alpha[4] = '0;                ph_gamma[4] = '1;
        ph_alpha[5] = COEF_W'($urandom_range(0, 65535));
        ph_gamma[5] = COEF_W'($urandom_range(0, 65535));
        ph_alpha[6] = COEF_W'($urandom_range(0, 65535));
        ph_gamma[6] = COEF_W'($urandom_range(0, 65535));

        // Directed table: cleared tables, unknown requests, empty successor rows
        add_row(REQ_READ,   0, 0,   0, 1, 0, 0, 0);
        add_row(REQ_READ,   7, 7, 255, 1, 0, 0, 0);
        add_row(REQ_NONE,   7, 7, 255, 1, 0, 0, 0);
        add_row(REQ_NONE,   0, 0,   0, 1, 0, 0, 0);
        add_row(REQ_UPDATE, 0, 0,   0, 1, 0, 0, 1);
        add_row(REQ_LOAD,   0, 1, 255, 1, 0, 0, 0);
        add_row(REQ_LOAD,   7, 7,   1, 1, 0, 0, 0);
        add_row(REQ_LOAD,   1, 0, 128, 1, 0, 0, 0);
        add_row(REQ_UPDATE, 0, 1,   0, 0, 0, 0, 0);
        add_row(REQ_UPDATE, 0, 1,   0, 0, 0, 0, 0);
        add_row(REQ_UPDATE, 1, 0,   0, 0, 0, 0, 0);
        add_row(REQ_UPDATE, 7, 7,   0, 0, 0, 0, 0);
        add_row(REQ_UPDATE, 7, 7,   0, 0, 0, 0, 0);
        add_row(REQ_READ,   0, 1,   0, 0, 0, 0, 0);
        add_row(REQ_LOAD,   0, 1,   0, 0, 0, 0, 0);
        add_row(REQ_UPDATE, 1, 0,   0, 0, 0, 0, 0);
        add_row(REQ_LOAD,   7, 0, 255, 0, 0, 0, 0);
        add_row(REQ_UPDATE, 6, 7,   0, 0, 0, 0, 0);
        add_row(REQ_READ,   7, 7,   0, 0, 0, 0, 0);
        add_row(REQ_UPDATE, 3, 2,   0, 1, 0, 0, 1);

        // Hold reset low, then release it
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            sender_gap();
            send_cmd(dir_rows[i].cmd, dir_rows[i].exact, dir_rows[i].res);
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            allow_gaps = (ph != NUM_PHASES - 1);
            if (ph == 0) begin
                // Writes past the register list must leave the coefficients alone
                cfg_write(CFG_SPARE_A, COEF_W'($urandom_range(0, 65535)));
                cfg_write(CFG_SPARE_B, COEF_W'($urandom_range(0, 65535)));
            end
            cfg_write(CFG_LEARN_RATE, ph_alpha[ph]);
            cfg_write(CFG_DISCOUNT, ph_gamma[ph]);

            // Drive a rewarded self loop into saturation at the Q maximum
            if (ph == 1) begin
                c = '0;
                c.req_type = REQ_LOAD;
                c.from_state = 3'd5;
                c.to_state = 3'd5;
                c.reward_in = '1;
                send_cmd(c, 1'b0, none);
                c.req_type = REQ_UPDATE;
                repeat (SATURATE_RUNS) begin
                    sender_gap();
                    send_cmd(c, 1'b0, none);
                end
            end

            repeat (PHASE_ITEMS) begin
                sender_gap();
                send_cmd(pick_cmd(), 1'b0, none);
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("** q_table_update: PASSED **");
        end else begin
            $display("** q_table_update: FAILED **");
        end
        $finish;
    end

endmodule
